>>> sv/tfc_pkg.sv
package tfc_pkg;

    localparam int DEF_BRANCH_BITS = 6;
    localparam int DEF_ROUND_COUNT = 7;
    localparam int DEF_TABLE_COUNT = 14;

    // width of the table select field
    localparam int SEL_BITS = 4;

    // transaction kinds carried on tuser
    localparam logic [1:0] KIND_ENC   = 2'd0;
    localparam logic [1:0] KIND_DEC   = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef struct packed {
        logic is_write;
        logic is_dec;
    } item_ctl_t;

endpackage

>>> sv/type2_feistel_cipher_7round.sv
// Four-branch Type-II Feistel cipher, ROUND_COUNT rounds on BRANCH_BITS-bit
// branches. Each round is one pipeline stage holding its own copies of the two
// S-box tables it needs (encrypt and decrypt regions), so a transaction enters
// every cycle unless back-pressure stalls the pipeline. A block passes through
// each round's stage register, with that round's registered table read taken
// as it enters the round, and then through the output register.
// tuser selects encrypt (0), decrypt (1) or an S-box entry write (2); writes
// travel down the pipeline and update each stage's copy in order with blocks,
// so a block sees every write accepted before it and none after. Writes and
// kind 3 give no result. Table entries must be written before they are read.
module type2_feistel_cipher_7round #(
    parameter int BRANCH_BITS = tfc_pkg::DEF_BRANCH_BITS,
    parameter int ROUND_COUNT = tfc_pkg::DEF_ROUND_COUNT,
    parameter int TABLE_COUNT = tfc_pkg::DEF_TABLE_COUNT,
    localparam int IN_BITS    = 6 * BRANCH_BITS + tfc_pkg::SEL_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((4 * BRANCH_BITS + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // branch_a_in, branch_b_in, branch_c_in, branch_d_in, table_select,
    // table_index, table_value
    input  logic [IN_W-1:0] s_axis_tdata,
    // kind
    input  logic [1:0]      s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // branch_a_out, branch_b_out, branch_c_out, branch_d_out
    output logic [OUT_W-1:0] m_axis_tdata
);

    import tfc_pkg::*;

    localparam int BB = BRANCH_BITS;

    logic                valid [ROUND_COUNT+1];
    logic                rdy   [ROUND_COUNT+1];
    item_ctl_t           ctl   [ROUND_COUNT+1];
    logic [BB-1:0]       ba    [ROUND_COUNT+1];
    logic [BB-1:0]       bb    [ROUND_COUNT+1];
    logic [BB-1:0]       bc    [ROUND_COUNT+1];
    logic [BB-1:0]       bd    [ROUND_COUNT+1];
    logic [SEL_BITS-1:0] sel   [ROUND_COUNT+1];
    logic [BB-1:0]       idx   [ROUND_COUNT+1];
    logic [BB-1:0]       val   [ROUND_COUNT+1];

    logic                out_valid_reg;
    logic [4*BB-1:0]     out_data_reg;
    logic                out_load;

    // input unpack, kind 3 is dropped at the door
    assign valid[0]        = s_axis_tvalid
                             && (s_axis_tuser inside {KIND_ENC, KIND_DEC, KIND_WRITE});
    assign ctl[0].is_write = (s_axis_tuser == KIND_WRITE);
    assign ctl[0].is_dec   = (s_axis_tuser == KIND_DEC);
    assign ba[0]           = s_axis_tdata[BB-1:0];
    assign bb[0]           = s_axis_tdata[2*BB-1:BB];
    assign bc[0]           = s_axis_tdata[3*BB-1:2*BB];
    assign bd[0]           = s_axis_tdata[4*BB-1:3*BB];
    assign sel[0]          = s_axis_tdata[4*BB+SEL_BITS-1:4*BB];
    assign idx[0]          = s_axis_tdata[5*BB+SEL_BITS-1:4*BB+SEL_BITS];
    assign val[0]          = s_axis_tdata[6*BB+SEL_BITS-1:5*BB+SEL_BITS];
    assign s_axis_tready   = rdy[0];

    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        tfc_round #(
            .BRANCH_BITS (BRANCH_BITS),
            .ROUND_COUNT (ROUND_COUNT),
            .TABLE_COUNT (TABLE_COUNT),
            .STAGE       (i)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (valid[i]),
            .ready     (rdy[i]),
            .src_ctl   (ctl[i]),
            .src_a     (ba[i]),
            .src_b     (bb[i]),
            .src_c     (bc[i]),
            .src_d     (bd[i]),
            .src_sel   (sel[i]),
            .src_idx   (idx[i]),
            .src_val   (val[i]),
            .dst_valid (valid[i+1]),
            .dst_ready (rdy[i+1]),
            .dst_ctl   (ctl[i+1]),
            .dst_a     (ba[i+1]),
            .dst_b     (bb[i+1]),
            .dst_c     (bc[i+1]),
            .dst_d     (bd[i+1]),
            .dst_sel   (sel[i+1]),
            .dst_idx   (idx[i+1]),
            .dst_val   (val[i+1])
        );
    end

    // output register, only blocks produce a result
    assign rdy[ROUND_COUNT] = !out_valid_reg || m_axis_tready;
    assign out_load = valid[ROUND_COUNT] && !ctl[ROUND_COUNT].is_write && rdy[ROUND_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy[ROUND_COUNT])
        begin
            out_valid_reg <= valid[ROUND_COUNT] && !ctl[ROUND_COUNT].is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {bd[ROUND_COUNT], bc[ROUND_COUNT], bb[ROUND_COUNT], ba[ROUND_COUNT]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[4*BB-1:0] = out_data_reg;
    end

    a_out_from_block: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(valid[ROUND_COUNT] && !ctl[ROUND_COUNT].is_write))
        else $error("result raised without a block leaving the last round");

    a_drop_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_ENC
            && s_axis_tuser != KIND_DEC && s_axis_tuser != KIND_WRITE |=> !valid[1])
        else $error("reserved kind entered the pipeline");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> valid[1])
        else $error("input stalled while first stage is empty");

endmodule

>>> sv/tfc_ram.sv
module tfc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 128,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tfc_round.sv
module tfc_round #(
    parameter int BRANCH_BITS = 6,
    parameter int ROUND_COUNT = 7,
    parameter int TABLE_COUNT = 14,
    parameter int STAGE       = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // upstream side
    input  logic                         src_valid,
    output logic                         ready,
    input  tfc_pkg::item_ctl_t           src_ctl,
    input  logic [BRANCH_BITS-1:0]       src_a,
    input  logic [BRANCH_BITS-1:0]       src_b,
    input  logic [BRANCH_BITS-1:0]       src_c,
    input  logic [BRANCH_BITS-1:0]       src_d,
    input  logic [tfc_pkg::SEL_BITS-1:0] src_sel,
    input  logic [BRANCH_BITS-1:0]       src_idx,
    input  logic [BRANCH_BITS-1:0]       src_val,
    // downstream side
    output logic                         dst_valid,
    input  logic                         dst_ready,
    output tfc_pkg::item_ctl_t           dst_ctl,
    output logic [BRANCH_BITS-1:0]       dst_a,
    output logic [BRANCH_BITS-1:0]       dst_b,
    output logic [BRANCH_BITS-1:0]       dst_c,
    output logic [BRANCH_BITS-1:0]       dst_d,
    output logic [tfc_pkg::SEL_BITS-1:0] dst_sel,
    output logic [BRANCH_BITS-1:0]       dst_idx,
    output logic [BRANCH_BITS-1:0]       dst_val
);

    import tfc_pkg::*;

    localparam int ENC_ROUND = STAGE + 1;
    localparam int DEC_ROUND = ROUND_COUNT - STAGE;
    localparam int TAB_E0    = (2 * ENC_ROUND - 2) % TABLE_COUNT;
    localparam int TAB_E1    = (2 * ENC_ROUND - 1) % TABLE_COUNT;
    localparam int TAB_D0    = (2 * DEC_ROUND - 2) % TABLE_COUNT;
    localparam int TAB_D1    = (2 * DEC_ROUND - 1) % TABLE_COUNT;
    localparam bit SHARED0   = (TAB_E0 == TAB_D0);
    localparam bit SHARED1   = (TAB_E1 == TAB_D1);
    localparam bit LAST      = (STAGE == ROUND_COUNT - 1);
    localparam int RAM_DEPTH = 2 << BRANCH_BITS;

    logic                   load;
    int                     sel_num;
    logic                   we0;
    logic                   we1;
    logic                   re;
    logic                   wdir0;
    logic                   wdir1;
    logic                   rdir0;
    logic                   rdir1;
    logic [BRANCH_BITS-1:0] rd0;
    logic [BRANCH_BITS-1:0] rd1;
    logic [BRANCH_BITS-1:0] nb;
    logic [BRANCH_BITS-1:0] nd;

    logic                   v_reg;
    item_ctl_t              ctl_reg;
    logic [BRANCH_BITS-1:0] a_reg;
    logic [BRANCH_BITS-1:0] b_reg;
    logic [BRANCH_BITS-1:0] c_reg;
    logic [BRANCH_BITS-1:0] d_reg;
    logic [SEL_BITS-1:0]    sel_reg;
    logic [BRANCH_BITS-1:0] idx_reg;
    logic [BRANCH_BITS-1:0] val_reg;

    assign ready = !v_reg || dst_ready;
    assign load  = src_valid && ready;

    // table writes land as the write transaction enters, so order is kept
    always_comb
    begin
        sel_num = int'(src_sel);
        re      = load && !src_ctl.is_write;
        we0     = load && src_ctl.is_write && (sel_num == TAB_E0 || sel_num == TAB_D0);
        we1     = load && src_ctl.is_write && (sel_num == TAB_E1 || sel_num == TAB_D1);
        wdir0   = (sel_num != TAB_E0);
        wdir1   = (sel_num != TAB_E1);
        rdir0   = SHARED0 ? 1'b0 : src_ctl.is_dec;
        rdir1   = SHARED1 ? 1'b0 : src_ctl.is_dec;
    end

    tfc_ram #(
        .WIDTH (BRANCH_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr ({wdir0, src_idx}),
        .wdata (src_val),
        .re    (re),
        .raddr ({rdir0, src_a}),
        .rdata (rd0)
    );

    tfc_ram #(
        .WIDTH (BRANCH_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr ({wdir1, src_idx}),
        .wdata (src_val),
        .re    (re),
        .raddr ({rdir1, src_c}),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready)
        begin
            v_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= src_ctl;
            a_reg   <= src_a;
            b_reg   <= src_b;
            c_reg   <= src_c;
            d_reg   <= src_d;
            sel_reg <= src_sel;
            idx_reg <= src_idx;
            val_reg <= src_val;
        end
    end

    assign nb = b_reg ^ rd0;
    assign nd = d_reg ^ rd1;

    always_comb
    begin
        if (LAST)
        begin
            dst_a = a_reg;
            dst_b = nb;
            dst_c = c_reg;
            dst_d = nd;
        end
        else if (!ctl_reg.is_dec)
        begin
            dst_a = nb;
            dst_b = c_reg;
            dst_c = nd;
            dst_d = a_reg;
        end
        else
        begin
            dst_a = nd;
            dst_b = a_reg;
            dst_c = nb;
            dst_d = c_reg;
        end
    end

    assign dst_valid = v_reg;
    assign dst_ctl   = ctl_reg;
    assign dst_sel   = sel_reg;
    assign dst_idx   = idx_reg;
    assign dst_val   = val_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && !dst_ready |=> v_reg && $stable(a_reg) && $stable(b_reg)
            && $stable(c_reg) && $stable(d_reg) && $stable(ctl_reg))
        else $error("stage contents changed while stalled");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(re && (we0 || we1)))
        else $error("table read and write in the same transaction");

    a_write_enters: assert property (@(posedge clk) disable iff (!rst_n)
        load && src_ctl.is_write |=> v_reg && ctl_reg.is_write)
        else $error("write transaction lost on entry");

endmodule
